// ----- rtl/fitness_key_sorter_defines.svh -----
// ---------------------------------------------------------------------------
// fitness_key_sorter_defines.svh
// Assertion macros used by the fitness key sorter datapath.
// ---------------------------------------------------------------------------
`ifndef FITNESS_KEY_SORTER_DEFINES_SVH
`define FITNESS_KEY_SORTER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define FKS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define FKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fks_pkg.sv -----
// ---------------------------------------------------------------------------
// fks_pkg
// Types and constants shared by the fitness key sorter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package fks_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 6;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INS,
    ST_CMP,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture an accepted transaction
    logic rd_prev;   // read the entry below the insertion slot
    logic shift;     // move the read entry up one slot
    logic put_key;   // write the new key into its slot
    logic out_rd;    // read the next sorted entry
    logic out_load;  // load the output register
    logic set_clear; // close the set
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;      // store holds the maximum number of keys
    logic j_zero;    // insertion slot is the bottom entry
    logic less;      // new key is below the entry read
    logic last;      // captured key closed the set
    logic out_busy;  // output register holds a result
    logic out_last;  // entry being emitted is the final one
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/fks_ram.sv -----
// ---------------------------------------------------------------------------
// fks_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module fks_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fks_ctrl.sv -----
// ---------------------------------------------------------------------------
// fks_ctrl
// Sequencer for load, insertion into sorted order, and read-out.
// ---------------------------------------------------------------------------
`default_nettype none

module fks_ctrl
  import fks_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic set_end,
  output logic      in_stall,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.full) begin
            state_next = ST_INS;
          end else if (set_end) begin
            state_next = ST_OUT_RD;
          end
        end
      end
      ST_INS: begin
        if (sts.j_zero) begin
          cmd.put_key = 1'b1;
          state_next  = sts.last ? ST_OUT_RD : ST_LOAD;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.less) begin
          cmd.shift  = 1'b1;
          state_next = ST_INS;
        end else begin
          cmd.put_key = 1'b1;
          state_next  = sts.last ? ST_OUT_RD : ST_LOAD;
        end
      end
      ST_OUT_RD: begin
        if (!sts.out_busy) begin
          cmd.out_rd = 1'b1;
          state_next = ST_OUT_LD;
        end
      end
      ST_OUT_LD: begin
        cmd.out_load = 1'b1;
        if (sts.out_last) begin
          cmd.set_clear = 1'b1;
          state_next    = ST_LOAD;
        end else begin
          state_next = ST_OUT_RD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/fks_dpath.sv -----
// ---------------------------------------------------------------------------
// fks_dpath
// Key store, insertion pointer, counters and output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "fitness_key_sorter_defines.svh"

module fks_dpath
  import fks_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic signed [KEY_W-1:0] fitness_key,
  input  wire logic                    set_end,
  input  wire cmd_t                    cmd,
  output sts_t                         sts,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output logic signed [KEY_W-1:0]      sorted_key,
  output logic        [TAG_W-1:0]      particle_tag,
  output logic                         run_last,
  output logic                         overflowed
);

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W  = KEY_W + TAG_W;

  logic [CNT_W-1:0]  count;
  logic              drop;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  o;
  logic [KEY_W-1:0]  key_r;
  logic [TAG_W-1:0]  tag_r;
  logic              last_r;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  logic [CNT_W-1:0]  j_dec;
  logic [CNT_W-1:0]  o_inc;

  assign j_dec = j - CNT_W'(1);
  assign o_inc = o + CNT_W'(1);

  // Store access: shifts move entries up, the new key lands in its slot
  assign ram_we    = cmd.put_key | cmd.shift;
  assign ram_waddr = j[ADDR_W-1:0];
  assign ram_wdata = cmd.put_key ? {key_r, tag_r} : ram_rdata;
  assign ram_re    = cmd.rd_prev | cmd.out_rd;
  assign ram_raddr = cmd.out_rd ? o[ADDR_W-1:0] : j_dec[ADDR_W-1:0];

  fks_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status
  assign sts.full     = (count == CNT_W'(MAX_ENTRIES));
  assign sts.j_zero   = (j == '0);
  assign sts.less     = $signed(key_r) < $signed(ram_rdata[ENT_W-1:TAG_W]);
  assign sts.last     = last_r;
  assign sts.out_busy = out_valid;
  assign sts.out_last = (o_inc == count);

  // Control registers: set fill, drop mark, insertion and read-out pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      drop      <= 1'b0;
      j         <= '0;
      o         <= '0;
      last_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        last_r <= set_end;
        j      <= count;
        if (sts.full) begin
          drop <= 1'b1;
        end
      end
      if (cmd.shift) begin
        j <= j_dec;
      end
      if (cmd.put_key) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.out_load) begin
        o <= o_inc;
      end
      if (cmd.set_clear) begin
        count <= '0;
        drop  <= 1'b0;
        o     <= '0;
      end
      // Output register handshake
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= fitness_key;
      tag_r <= TAG_W'(count);
    end
    if (cmd.out_load) begin
      sorted_key   <= ram_rdata[ENT_W-1:TAG_W];
      particle_tag <= ram_rdata[TAG_W-1:0];
      run_last     <= sts.out_last;
      overflowed   <= drop;
    end
  end

  `FKS_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_ENTRIES), "fill count beyond capacity")
  `FKS_ASSERT_NOW(a_out_no_clobber, cmd.out_load, !out_valid, "output register overwritten")
  `FKS_ASSERT_NOW(a_put_has_room, cmd.put_key, !sts.full && (j <= count), "insert with no room")
  `FKS_ASSERT_NEXT(a_clear_after_last, cmd.out_load && sts.out_last, count == '0 && !drop,
                   "set not closed after final result")

endmodule

`default_nettype wire

// ----- rtl/fitness_key_sorter.sv -----
// ---------------------------------------------------------------------------
// fitness_key_sorter
// Collects a set of signed Q16.16 fitness keys and emits them sorted.
// ---------------------------------------------------------------------------
// Keys arrive one per transaction; set_end closes the set. Each stored key is
// tagged with its arrival index (modulo 64) and inserted into ascending order
// in a single RAM as it arrives, after any equal keys, so ties keep arrival
// order. A key is accepted, then each stored key greater than it is read and
// shifted up one slot through the one RAM read/write port; the key is written
// once a read entry is not greater than it, or directly when it reaches the
// bottom slot, as the first key of a set does.
// After the closing key the set is read out one result at a time: registered
// RAM read, output register load, then the result waits in the output
// register until it leaves while out_stall is low; the next read waits for it.
// Keys beyond MAX_ENTRIES are dropped and every result of that set carries
// overflowed; run_last marks the final result. A new set may start loading
// while the final result still waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module fitness_key_sorter
  import fks_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [KEY_W-1:0] fitness_key,
  input  wire logic                    set_end,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [KEY_W-1:0]      sorted_key,
  output logic        [TAG_W-1:0]      particle_tag,
  output logic                         run_last,
  output logic                         overflowed
);

  cmd_t cmd;
  sts_t sts;

  fks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .set_end  (set_end),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  fks_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .fitness_key  (fitness_key),
    .set_end      (set_end),
    .cmd          (cmd),
    .sts          (sts),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .sorted_key   (sorted_key),
    .particle_tag (particle_tag),
    .run_last     (run_last),
    .overflowed   (overflowed)
  );

endmodule

`default_nettype wire
